### src/cmb_pkg.sv
`default_nettype none

package cmb_pkg;

  // Largest surface or framebuffer dimension that enables writes
  localparam int MAX_DIM = 1024;
  // Column and row counter width
  localparam int CNT_W   = $clog2(MAX_DIM);
  // Width of the configuration dimension and corner registers
  localparam int DIM_W   = 11;
  // Compare and sum width covering both counters and dimensions
  localparam int CMP_W   = ((CNT_W > DIM_W) ? CNT_W : DIM_W) + 1;
  localparam int PIX_W   = 8;
  localparam int ADDR_W  = 20;
  localparam int PROD_W  = 2 * DIM_W;
  localparam int IDX_W   = 3;

  // Entries in the queue between front and back
  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = QPTR_W + 1;

  typedef enum logic [IDX_W-1:0] {
    REG_SURFACE_WIDTH  = 3'd0,
    REG_SURFACE_HEIGHT = 3'd1,
    REG_FRAME_WIDTH    = 3'd2,
    REG_FRAME_HEIGHT   = 3'd3,
    REG_DEST_X         = 3'd4,
    REG_DEST_Y         = 3'd5,
    REG_MIRROR         = 3'd6
  } reg_index_t;

  typedef struct packed {
    logic [DIM_W-1:0] surface_width;
    logic [DIM_W-1:0] surface_height;
    logic [DIM_W-1:0] frame_width;
    logic [DIM_W-1:0] frame_height;
    logic [DIM_W-1:0] dest_x;
    logic [DIM_W-1:0] dest_y;
    logic             mirror;
  } cfg_t;

  // One classified write travelling from front to back
  typedef struct packed {
    logic [DIM_W-1:0] ysum;
    logic [DIM_W-1:0] xsum;
    logic [PIX_W-1:0] pixel;
    logic             last;
  } entry_t;

  typedef struct packed {
    logic             fit;
    logic [DIM_W-1:0] pos;
  } corner_t;

  function automatic logic dim_ok(input logic [DIM_W-1:0] v);
    return (v != '0) && (CMP_W'(v) <= CMP_W'(MAX_DIM));
  endfunction

  function automatic logic [DIM_W-1:0] dim_sat(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (CMP_W'(v) > CMP_W'(MAX_DIM)) begin
      r = DIM_W'(MAX_DIM);
    end
    return r;
  endfunction

  // Clamp a two's complement corner so that size fits within extent
  function automatic corner_t clamp_corner(input logic [DIM_W-1:0] raw,
                                           input logic [DIM_W-1:0] size,
                                           input logic [DIM_W-1:0] extent);
    corner_t          c;
    logic [DIM_W-1:0] p;
    logic [CMP_W-1:0] reach;
    p     = raw[DIM_W-1] ? '0 : {1'b0, raw[DIM_W-2:0]};
    reach = CMP_W'(p) + CMP_W'(size);
    c.fit = (size <= extent);
    c.pos = (reach > CMP_W'(extent)) ? DIM_W'(extent - size) : p;
    return c;
  endfunction

endpackage

`default_nettype wire

### src/clipped_mirrored_blit.sv
`default_nettype none

// Clipped rectangle blit with horizontal mirror.
//
// Input channel (in_valid / in_ready / src_pixel): one beat per source pixel,
// row-major. Output channel (out_valid / out_ready): one framebuffer write
// per drawable pixel, carrying write_address = row * frame_width + column,
// out_pixel and final_write (set on the last surface pixel). Pixels whose
// blit cannot be drawn (surface larger than the frame, or a dimension
// register of 0 or above MAX_DIM) are consumed with no write.
// Configuration: pulse cfg_we with cfg_index / cfg_data; write only while
// no pixel is in flight.
// Throughput: one pixel per clock while out_ready is high. A pixel passes
// front classify, queue, multiply stage and output register in that order;
// the multiply of row by frame_width has a stage of its own.
// A four-beat queue parts the classifier from the address pipeline; when
// out_ready stays low the pipeline holds and the queue fills, then
// in_ready drops. Nothing is lost or repeated.
// Reset: registers return to a 48x48 surface at the top-left corner of a
// 320x200 frame, no mirror, counters at the first pixel, all channels empty.
// Counters wrap after the last pixel, ready for the next blit.

module clipped_mirrored_blit
  import cmb_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic [IDX_W-1:0]  cfg_index,
  input  wire logic [DIM_W-1:0]  cfg_data,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [PIX_W-1:0]  src_pixel,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [ADDR_W-1:0]      write_address,
  output logic [PIX_W-1:0]       out_pixel,
  output logic                   final_write
);

  cfg_t   cfg;
  logic   q_full;
  logic   q_nonempty;
  logic   push;
  logic   pop;
  entry_t push_entry;
  entry_t q_head;

  // Configuration registers; indexes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.surface_width  <= DIM_W'(48);
      cfg.surface_height <= DIM_W'(48);
      cfg.frame_width    <= DIM_W'(320);
      cfg.frame_height   <= DIM_W'(200);
      cfg.dest_x         <= '0;
      cfg.dest_y         <= '0;
      cfg.mirror         <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SURFACE_WIDTH:  cfg.surface_width  <= cfg_data;
        REG_SURFACE_HEIGHT: cfg.surface_height <= cfg_data;
        REG_FRAME_WIDTH:    cfg.frame_width    <= cfg_data;
        REG_FRAME_HEIGHT:   cfg.frame_height   <= cfg_data;
        REG_DEST_X:         cfg.dest_x         <= cfg_data;
        REG_DEST_Y:         cfg.dest_y         <= cfg_data;
        REG_MIRROR:         cfg.mirror         <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // Front: accept, track position, clip and mirror
  cmb_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .src_pixel  (src_pixel),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  // Queue: decouple front stalls from back stalls
  cmb_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .nonempty   (q_nonempty),
    .head       (q_head)
  );

  // Back: form the linear address and drive the write beat
  cmb_back u_back (
    .clk           (clk),
    .rst           (rst),
    .frame_width   (cfg.frame_width),
    .q_nonempty    (q_nonempty),
    .q_head        (q_head),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .write_address (write_address),
    .out_pixel     (out_pixel),
    .final_write   (final_write)
  );

endmodule

`default_nettype wire

### src/cmb_front.sv
`default_nettype none

module cmb_front
  import cmb_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire cfg_t             cfg,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [PIX_W-1:0] src_pixel,
  input  wire logic             q_full,
  output logic                  push,
  output entry_t                push_entry
);

  logic [CNT_W-1:0] column_count;
  logic [CNT_W-1:0] row_count;
  logic [CNT_W-1:0] column_count_next;
  logic [CNT_W-1:0] row_count_next;

  logic [DIM_W-1:0] w;
  logic [DIM_W-1:0] h;
  logic             enabled;
  corner_t          cx;
  corner_t          cy;
  logic             in_range;
  logic             emit;
  logic [CNT_W-1:0] dcol;
  logic [CMP_W-1:0] col_inc;
  logic [CMP_W-1:0] row_inc;
  logic             accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    w       = dim_sat(cfg.surface_width);
    h       = dim_sat(cfg.surface_height);
    enabled = dim_ok(cfg.surface_width) && dim_ok(cfg.surface_height) &&
              dim_ok(cfg.frame_width) && dim_ok(cfg.frame_height);
    cx      = clamp_corner(cfg.dest_x, cfg.surface_width, cfg.frame_width);
    cy      = clamp_corner(cfg.dest_y, cfg.surface_height, cfg.frame_height);
    in_range = (CMP_W'(column_count) < CMP_W'(w)) && (CMP_W'(row_count) < CMP_W'(h));
    emit    = enabled && in_range && cx.fit && cy.fit;
    dcol    = cfg.mirror ? CNT_W'(CMP_W'(w) - CMP_W'(1) - CMP_W'(column_count))
                         : column_count;

    push_entry.xsum  = DIM_W'(CMP_W'(cx.pos) + CMP_W'(dcol));
    push_entry.ysum  = DIM_W'(CMP_W'(cy.pos) + CMP_W'(row_count));
    push_entry.pixel = src_pixel;
    push_entry.last  = (CMP_W'(column_count) == CMP_W'(w) - CMP_W'(1)) &&
                       (CMP_W'(row_count) == CMP_W'(h) - CMP_W'(1));
    push = accept && emit;

    // Wrap the column at the row end, the row at the surface end
    col_inc = CMP_W'(column_count) + CMP_W'(1);
    row_inc = CMP_W'(row_count) + CMP_W'(1);
    column_count_next = column_count;
    row_count_next    = row_count;
    if (col_inc >= CMP_W'(w)) begin
      column_count_next = '0;
      row_count_next    = (row_inc >= CMP_W'(h)) ? '0 : CNT_W'(row_inc);
    end else begin
      column_count_next = CNT_W'(col_inc);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (accept) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
    end
  end

  a_push_needs_accept: assert property (@(posedge clk) disable iff (rst)
    push |-> (in_valid && !q_full))
    else $error("front pushed without an accepted beat");

endmodule

`default_nettype wire

### src/cmb_queue.sv
`default_nettype none

module cmb_queue
  import cmb_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   push,
  input  wire entry_t push_entry,
  output logic        full,
  input  wire logic   pop,
  output logic        nonempty,
  output entry_t      head
);

  entry_t             store [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  count;
  logic [QCNT_W-1:0]  count_next;

  assign full     = (count == QCNT_W'(QDEPTH));
  assign nonempty = (count != '0);
  assign head     = store[rd_ptr];

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + QCNT_W'(1);
    end else if (pop && !push) begin
      count_next = count - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      count <= count_next;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (!full || pop))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> nonempty)
    else $error("queue read while empty");

endmodule

`default_nettype wire

### src/cmb_back.sv
`default_nettype none

module cmb_back
  import cmb_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [DIM_W-1:0]  frame_width,
  input  wire logic              q_nonempty,
  input  wire entry_t            q_head,
  output logic                   pop,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [ADDR_W-1:0]      write_address,
  output logic [PIX_W-1:0]       out_pixel,
  output logic                   final_write
);

  // Multiply stage
  logic              m_valid;
  logic [PROD_W-1:0] m_prod;
  logic [DIM_W-1:0]  m_xsum;
  logic [PIX_W-1:0]  m_pixel;
  logic              m_last;

  logic              o_load;
  logic              m_ready;
  logic [PROD_W:0]   addr_sum;

  assign o_load   = m_valid && (!out_valid || out_ready);
  assign m_ready  = !m_valid || o_load;
  assign pop      = q_nonempty && m_ready;
  assign addr_sum = (PROD_W + 1)'(m_prod) + (PROD_W + 1)'(m_xsum);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (m_ready) begin
      m_valid <= q_nonempty;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      m_prod  <= PROD_W'(q_head.ysum) * PROD_W'(frame_width);
      m_xsum  <= q_head.xsum;
      m_pixel <= q_head.pixel;
      m_last  <= q_head.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (o_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (o_load) begin
      write_address <= addr_sum[ADDR_W-1:0];
      out_pixel     <= m_pixel;
      final_write   <= m_last;
    end
  end

  a_mult_holds: assert property (@(posedge clk) disable iff (rst)
    (m_valid && !o_load) |=> (m_valid && $stable(m_prod) && $stable(m_xsum)))
    else $error("multiply stage lost its beat while stalled");

endmodule

`default_nettype wire

### test/tb.sv
`timescale 1ns / 100ps

// Clipped, mirrored blit: drive source pixels against random stalls on both
// channels, predict every framebuffer write and compare each beat as it leaves.
module tb;
  import cmb_pkg::*;

  // Index 7 decodes to no register; a write there must change nothing
  localparam logic [IDX_W-1:0] REG_SPARE = 3'd7;
  // Idle cycles after the last write before touching registers
  localparam int SETTLE_CYCLES = 8;
  // Cycles with no beat on either channel before the run is declared hung
  localparam int STALL_LIMIT   = 1000;
  // Pixels that must land in the framebuffer before the random part stops
  localparam int TARGET_DRAWN  = 2000;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [PIX_W-1:0]  pixel;
    logic              last;
  } fb_write_t;

  typedef struct packed {
    logic [DIM_W-1:0] surf_w;
    logic [DIM_W-1:0] surf_h;
    logic [DIM_W-1:0] frame_w;
    logic [DIM_W-1:0] frame_h;
    logic [DIM_W-1:0] org_x;
    logic [DIM_W-1:0] org_y;
    logic             flip;
  } blit_cfg_t;

  // Directed rows: a register write, a pixel checked against the predictor,
  // a pixel with its write typed in, or a pixel that must draw nothing
  typedef enum logic [1:0] {ROW_REG, ROW_PIX, ROW_PIX_WRITE, ROW_PIX_SKIP} row_kind_t;

  typedef struct packed {
    row_kind_t         kind;
    logic [IDX_W-1:0]  idx;
    logic [DIM_W-1:0]  data;
    logic [PIX_W-1:0]  pixel;
    logic [ADDR_W-1:0] addr;
    logic              last;
  } plan_row_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_we = 1'b0;
  logic [IDX_W-1:0]  cfg_index = '0;
  logic [DIM_W-1:0]  cfg_data = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [PIX_W-1:0]  src_pixel = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [ADDR_W-1:0] write_address;
  logic [PIX_W-1:0]  out_pixel;
  logic              final_write;

  // Predictor copy of the registers and of the source position
  blit_cfg_t regs = '{11'd48, 11'd48, 11'd320, 11'd200, 11'd0, 11'd0, 1'b0};
  logic [CNT_W-1:0] src_col = '0;
  logic [CNT_W-1:0] src_row = '0;

  fb_write_t pending_writes [$];
  plan_row_t plan [$];
  int        n_miss = 0;
  int        drawn = 0;
  int        idle_cycles = 0;
  bit        quick = 1'b0;

  always #1 clk = ~clk;

  clipped_mirrored_blit dut (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .in_valid, .in_ready, .src_pixel,
    .out_valid, .out_ready, .write_address, .out_pixel, .final_write
  );

  // ---------------------------------------------------------------- predictor

  function automatic bit legal_dim(input logic [DIM_W-1:0] v);
    return (v != 0) && (v <= MAX_DIM);
  endfunction

  // Counting size: an illegal dimension still steps the counters within 1..MAX_DIM
  function automatic int unsigned sat_dim(input logic [DIM_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return v;
  endfunction

  // Negative corners snap to 0; an overhang is pulled back to end at the edge
  function automatic bit fit_corner(input logic [DIM_W-1:0] raw, input int unsigned size,
                                    input int unsigned extent, output int unsigned pos);
    pos = raw[DIM_W-1] ? 0 : raw[DIM_W-2:0];
    if (pos + size > extent) pos = extent - size;
    return size <= extent;
  endfunction

  // Work out the write for one source pixel and step the source position
  function automatic bit trace_pixel(input logic [PIX_W-1:0] pix, output fb_write_t wr);
    int unsigned w, h, col, row, x0, y0, dcol;
    bit fit_x, fit_y, live;
    w     = sat_dim(regs.surf_w);
    h     = sat_dim(regs.surf_h);
    col   = src_col;
    row   = src_row;
    fit_x = fit_corner(regs.org_x, regs.surf_w, regs.frame_w, x0);
    fit_y = fit_corner(regs.org_y, regs.surf_h, regs.frame_h, y0);
    // a position left past a shrunk surface draws nothing but still wraps
    live  = legal_dim(regs.surf_w) && legal_dim(regs.surf_h) &&
            legal_dim(regs.frame_w) && legal_dim(regs.frame_h) &&
            col < w && row < h && fit_x && fit_y;
    dcol     = regs.flip ? w - 1 - col : col;
    wr.addr  = ADDR_W'((y0 + row) * regs.frame_w + x0 + dcol);
    wr.pixel = pix;
    wr.last  = (col == w - 1) && (row == h - 1);
    if (col + 1 >= w) begin
      src_col = '0;
      src_row = (row + 1 >= h) ? '0 : CNT_W'(row + 1);
    end else begin
      src_col = CNT_W'(col + 1);
    end
    return live;
  endfunction

  // Pixels still needed to bring the source position back to the corner
  function automatic int steps_to_origin();
    int unsigned w, h, c, r;
    int k;
    w = sat_dim(regs.surf_w);
    h = sat_dim(regs.surf_h);
    c = src_col;
    r = src_row;
    k = 0;
    while (c != 0 || r != 0) begin
      if (c + 1 >= w) begin
        c = 0;
        r = (r + 1 >= h) ? 0 : r + 1;
      end else begin
        c = c + 1;
      end
      k++;
    end
    return k;
  endfunction

  // ---------------------------------------------------------------- drivers

  // Hold the write strobe for one edge, then leave a quiet cycle
  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DIM_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_SURFACE_WIDTH:  regs.surf_w  = data;
      REG_SURFACE_HEIGHT: regs.surf_h  = data;
      REG_FRAME_WIDTH:    regs.frame_w = data;
      REG_FRAME_HEIGHT:   regs.frame_h = data;
      REG_DEST_X:         regs.org_x   = data;
      REG_DEST_Y:         regs.org_y   = data;
      REG_MIRROR:         regs.flip    = data[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Offer one pixel beat; keep valid up into the next beat only when it
  // follows with no gap, so valid never drops and rises in one step
  task automatic push_pixel(input logic [PIX_W-1:0] pix, input bit more,
                            input row_kind_t mode, input fb_write_t typed);
    fb_write_t wr;
    bit hit;
    int gap;
    in_valid  <= 1'b1;
    src_pixel <= pix;
    do @(posedge clk); while (!in_ready);
    hit = trace_pixel(pix, wr);
    if (hit) drawn++;
    case (mode)
      ROW_PIX_WRITE: pending_writes.push_back(typed);
      ROW_PIX_SKIP:  ;
      default:       if (hit) pending_writes.push_back(wr);
    endcase
    gap = quick ? 0 : $urandom_range(0, 5);
    if (!more || gap != 0) in_valid <= 1'b0;
    if (more) repeat (gap) @(posedge clk);
  endtask

  // Pause the sender until every write has left, then let pixels that draw
  // nothing clear the pipe
  task automatic settle();
    while (pending_writes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One random blit setting followed by its pixels
  task automatic run_phase();
    int unsigned sw, sh, fw, fh, body, total;
    logic [DIM_W-1:0] dx, dy, bad;
    int kind;
    settle();
    kind = $urandom_range(0, 9);
    quick = ($urandom_range(0, 3) == 0);
    // mostly small surfaces; now and then one wide single row
    if ($urandom_range(0, 15) == 0) begin
      sw = $urandom_range(256, MAX_DIM);
      sh = 1;
    end else begin
      sw = $urandom_range(1, 12);
      sh = $urandom_range(1, 12);
    end
    fw = $urandom_range(sw, MAX_DIM);
    fh = $urandom_range(sh, MAX_DIM);
    dx = $urandom_range(0, 1) ? DIM_W'($urandom_range(0, 2047)) : DIM_W'($urandom_range(0, 24));
    dy = $urandom_range(0, 1) ? DIM_W'($urandom_range(0, 2047)) : DIM_W'($urandom_range(0, 24));
    body = sw * sh * $urandom_range(1, 2);
    case (kind)
      7: begin
        // surface overhangs the frame in one direction: nothing drawn
        if ($urandom_range(0, 1)) begin
          if (sw < 2) sw = 2;
          fw = $urandom_range(1, sw - 1);
        end else begin
          if (sh < 2) sh = 2;
          fh = $urandom_range(1, sh - 1);
        end
        body = $urandom_range(1, 30);
      end
      8: begin
        // one dimension register zero or above the maximum
        bad = $urandom_range(0, 1) ? '0 : DIM_W'($urandom_range(MAX_DIM + 1, 2047));
        case ($urandom_range(0, 3))
          0: sw = bad;
          1: sh = bad;
          2: fw = bad;
          default: fh = bad;
        endcase
        body = $urandom_range(1, 30);
      end
      9: begin
        // raw noise over the full register range
        sw = $urandom_range(0, 2047);
        sh = $urandom_range(0, 2047);
        fw = $urandom_range(0, 2047);
        fh = $urandom_range(0, 2047);
        body = $urandom_range(1, 30);
      end
      default: ;
    endcase
    write_reg(REG_SURFACE_WIDTH, DIM_W'(sw));
    write_reg(REG_SURFACE_HEIGHT, DIM_W'(sh));
    write_reg(REG_FRAME_WIDTH, DIM_W'(fw));
    write_reg(REG_FRAME_HEIGHT, DIM_W'(fh));
    write_reg(REG_DEST_X, dx);
    write_reg(REG_DEST_Y, dy);
    write_reg(REG_MIRROR, DIM_W'($urandom_range(0, 1)));
    // well-formed blits first run out whatever the last setting left behind
    total = ((kind < 7) ? steps_to_origin() : 0) + body;
    for (int i = 0; i < total; i++)
      push_pixel(PIX_W'($urandom_range(0, 255)), i + 1 < total, ROW_PIX, '0);
  endtask

  // ---------------------------------------------------------------- directed table

  function automatic plan_row_t rg(input logic [IDX_W-1:0] idx, input int data);
    return '{ROW_REG, idx, DIM_W'(data), '0, '0, 1'b0};
  endfunction

  function automatic plan_row_t px(input logic [PIX_W-1:0] pix);
    return '{ROW_PIX, '0, '0, pix, '0, 1'b0};
  endfunction

  function automatic plan_row_t pxw(input logic [PIX_W-1:0] pix, input int addr,
                                    input logic last);
    return '{ROW_PIX_WRITE, '0, '0, pix, ADDR_W'(addr), last};
  endfunction

  function automatic plan_row_t pxs(input logic [PIX_W-1:0] pix);
    return '{ROW_PIX_SKIP, '0, '0, pix, '0, 1'b0};
  endfunction

  task automatic load_plan();
    // reset setting: 48x48 at the top-left of a 320x200 frame
    plan.push_back(pxw(8'h00, 0, 1'b0));
    plan.push_back(pxw(8'hFF, 1, 1'b0));
    plan.push_back(px(8'h5A));
    // shrink to 1x1 with the column already past it: drop one, then wrap
    plan.push_back(rg(REG_SURFACE_WIDTH, 1));
    plan.push_back(rg(REG_SURFACE_HEIGHT, 1));
    plan.push_back(pxs(8'h11));
    plan.push_back(pxw(8'h22, 0, 1'b1));
    // negative x snaps to 0, far y is pulled back to the bottom row
    plan.push_back(rg(REG_DEST_X, 11'h7FF));
    plan.push_back(rg(REG_DEST_Y, 11'h3FF));
    plan.push_back(pxw(8'h33, 199 * 320, 1'b1));
    // largest frame, corner in the last cell: top address
    plan.push_back(rg(REG_FRAME_WIDTH, MAX_DIM));
    plan.push_back(rg(REG_FRAME_HEIGHT, MAX_DIM));
    plan.push_back(rg(REG_DEST_X, 11'h3FF));
    plan.push_back(pxw(8'h44, 20'hFFFFF, 1'b1));
    // most negative corner, mirrored 3x2 surface in a 5x4 frame
    plan.push_back(rg(REG_DEST_X, 11'h400));
    plan.push_back(rg(REG_DEST_Y, 11'h400));
    plan.push_back(rg(REG_MIRROR, 1));
    plan.push_back(rg(REG_SURFACE_WIDTH, 3));
    plan.push_back(rg(REG_SURFACE_HEIGHT, 2));
    plan.push_back(rg(REG_FRAME_WIDTH, 5));
    plan.push_back(rg(REG_FRAME_HEIGHT, 4));
    plan.push_back(px(8'h01));
    plan.push_back(px(8'h80));
    plan.push_back(px(8'h7F));
    plan.push_back(px(8'hAA));
    plan.push_back(px(8'h55));
    plan.push_back(px(8'hFE));
    // surface wider than the frame
    plan.push_back(rg(REG_FRAME_WIDTH, 2));
    plan.push_back(pxs(8'hC3));
    // frame height zero, then above the maximum
    plan.push_back(rg(REG_FRAME_WIDTH, MAX_DIM));
    plan.push_back(rg(REG_FRAME_HEIGHT, 0));
    plan.push_back(pxs(8'h3C));
    plan.push_back(rg(REG_FRAME_HEIGHT, 2047));
    plan.push_back(pxs(8'hE7));
    // surface width above the maximum, then zero
    plan.push_back(rg(REG_FRAME_HEIGHT, MAX_DIM));
    plan.push_back(rg(REG_SURFACE_WIDTH, 2047));
    plan.push_back(pxs(8'h18));
    plan.push_back(pxs(8'h81));
    plan.push_back(rg(REG_SURFACE_WIDTH, 0));
    plan.push_back(pxs(8'h66));
    // full-width single row, straight copy; the spare index must not land
    plan.push_back(rg(REG_SURFACE_WIDTH, MAX_DIM));
    plan.push_back(rg(REG_SURFACE_HEIGHT, 1));
    plan.push_back(rg(REG_MIRROR, 0));
    plan.push_back(rg(REG_DEST_X, 0));
    plan.push_back(rg(REG_DEST_Y, 0));
    plan.push_back(rg(REG_SPARE, 11'h7FF));
    plan.push_back(pxw(8'h99, 0, 1'b0));
    plan.push_back(px(8'h0F));
  endtask

  // ---------------------------------------------------------------- sink side

  // Draw a random stall after each accepted write; now and then run
  // a calm stretch with ready held high
  int sink_wait = 0;
  int sink_calm = 0;

  always @(posedge clk) begin : sink
    int draw;
    if (rst) begin
      out_ready <= 1'b0;
      sink_wait <= 0;
      sink_calm <= 0;
    end else if (out_ready && out_valid) begin
      draw = (sink_calm > 0) ? 0 : $urandom_range(0, 5);
      if (sink_calm > 0) sink_calm <= sink_calm - 1;
      else if ($urandom_range(0, 49) == 0) sink_calm <= 40;
      if (draw != 0) begin
        out_ready <= 1'b0;
        sink_wait <= draw;
      end
    end else if (!out_ready) begin
      if (sink_wait <= 1) out_ready <= 1'b1;
      sink_wait <= sink_wait - 1;
    end
  end

  // ---------------------------------------------------------------- checking

  function automatic void note_miss(input string what, input fb_write_t want,
                                    input fb_write_t got);
    if (n_miss < 10)
      $display("tb: %0t mismatch on %s: expected addr %0d pix %02h last %0b,",
               $realtime, what, want.addr, want.pixel, want.last,
               " got addr %0d pix %02h last %0b", got.addr, got.pixel, got.last);
    n_miss++;
  endfunction

  // Compare every accepted write beat with the oldest expectation
  always @(posedge clk) begin : check_beat
    fb_write_t got, want;
    if (!rst && out_valid && out_ready) begin
      got.addr  = write_address;
      got.pixel = out_pixel;
      got.last  = final_write;
      if (pending_writes.size() == 0) begin
        note_miss("write with none pending", '0, got);
      end else begin
        want = pending_writes.pop_front();
        if (got.addr !== want.addr) note_miss("write_address", want, got);
        if (got.pixel !== want.pixel) note_miss("out_pixel", want, got);
        if (got.last !== want.last) note_miss("final_write", want, got);
      end
    end
  end

  // Hang detector: any beat on either channel restarts the count
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin : stimulus
    bit more;
    fb_write_t typed;
    load_plan();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Walk the directed table; settle before any register write that
    // follows pixels
    for (int i = 0; i < plan.size(); i++) begin
      if (plan[i].kind == ROW_REG) begin
        if (i > 0 && plan[i - 1].kind != ROW_REG) settle();
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        more        = (i + 1 < plan.size()) && (plan[i + 1].kind != ROW_REG);
        typed.addr  = plan[i].addr;
        typed.pixel = plan[i].pixel;
        typed.last  = plan[i].last;
        push_pixel(plan[i].pixel, more, plan[i].kind, typed);
      end
    end

    // Random settings until enough pixels have been drawn
    while (drawn < TARGET_DRAWN) run_phase();

    // Drain, then give stray writes time to show up
    while (pending_writes.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (n_miss == 0 && pending_writes.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

### files.f
src/cmb_pkg.sv
src/cmb_front.sv
src/cmb_queue.sv
src/cmb_back.sv
src/clipped_mirrored_blit.sv
test/tb.sv
